// ----- hdl/sha256_message_hash_assert.svh -----
// ----------------------------------------------------------------------------
// SHA-256 message hash assertion macros
// Concurrent assertion helpers, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASH_ASSERT_SVH
`define SHA256_MESSAGE_HASH_ASSERT_SVH

// Check a property at every rising edge outside reset.
`define SHAMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication whose consequent must hold in the cycle after its antecedent.
`define SHAMH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- hdl/shamh_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 message hash package
// Round constants, initial hash values and shared control types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shamh_pkg;

  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] LastWord  = 6'd8;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_LOAD  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_FINAL = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic       load;   // shift a chain word into the working registers
    logic       round;  // run one compression round
    logic       fin;    // add chain word to working word and shift the sum in
    logic [5:0] rnd;    // round index
  } core_ctl_t;

endpackage

// ----- hdl/shamh_buf.sv -----
// ----------------------------------------------------------------------------
// SHA-256 block buffer
// Packs bytes into big-endian words and stores the 16-word block in memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shamh_buf (
  input  logic        clk_i,
  input  logic        byte_we_i,
  input  logic [7:0]  byte_i,
  input  logic [5:0]  fill_i,
  input  logic [3:0]  raddr_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem [16];
  logic [23:0] acc_q;
  logic [31:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (byte_we_i) begin
      if (fill_i[1:0] == 2'd3) begin
        mem[fill_i[5:2]] <= {acc_q, byte_i};
      end else begin
        acc_q <= {acc_q[15:0], byte_i};
      end
    end
    rd_q <= mem[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

// ----- hdl/shamh_chain.sv -----
// ----------------------------------------------------------------------------
// SHA-256 chain value store
// Eight-word memory; reads return the initial hash while a message is fresh.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shamh_chain (
  input  logic        clk_i,
  input  logic        fresh_i,
  input  logic [2:0]  raddr_i,
  input  logic        we_i,
  input  logic [2:0]  waddr_i,
  input  logic [31:0] wdata_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem [8];
  logic [31:0] rd_q;
  logic [2:0]  sel_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q  <= mem[raddr_i];
    sel_q <= raddr_i;
  end

  // the first block of a message starts from the initial hash, not the store
  assign rdata_o = fresh_i ? shamh_pkg::InitHash[sel_q] : rd_q;

endmodule

// ----- hdl/shamh_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round core
// Working variables, message schedule window and one round per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shamh_core (
  input  logic                 clk_i,
  input  shamh_pkg::core_ctl_t ctl_i,
  input  logic [31:0]          chain_i,
  input  logic [31:0]          blk_i,
  output logic [31:0]          sum_o,
  output logic [255:0]         digest_o
);

  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] w_new, s1e, ch, t1, s0a, maj, t2;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    if (ctl_i.rnd[5:4] == 2'd0) begin
      w_new = blk_i;
    end else begin
      w_new = w_q[0] + (ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[9]
              + (ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10));
    end
    s1e = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + s1e + ch + shamh_pkg::RoundK[ctl_i.rnd] + w_new;
    s0a = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = s0a + maj;
  end

  assign sum_o = chain_i + v_q[0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.load || ctl_i.fin) begin
      for (int i = 0; i < 7; i++) begin
        v_q[i] <= v_q[i + 1];
      end
      v_q[7] <= ctl_i.fin ? sum_o : chain_i;
    end else if (ctl_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (ctl_i.round) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[15] <= w_new;
    end
  end

  assign digest_o = {v_q[6], v_q[7], v_q[4], v_q[5], v_q[2], v_q[3], v_q[0], v_q[1]};

endmodule

// ----- hdl/sha256_message_hash.sv -----
// ----------------------------------------------------------------------------
// SHA-256 message hash
// Byte-stream SHA-256 with internal padding and a registered digest output.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one transaction per item. tdata[7:0] is the message byte,
//   tuser says the byte is present, tlast marks the final item of a message.
//   Master channel: one transaction per message, the 256-bit digest.
//   Bytes are taken one per cycle while a block gathers. Each full block then
//   holds tready low while it reads the chain value out of its memory, runs
//   64 rounds in the round core, and adds and writes the chain back.
//   After tlast the block writes padding bytes one per cycle (up to 64, or
//   up to 72 when a second block is needed), compresses, and loads the
//   digest into the output register, then takes the next message.
//   A finished digest waits in its output register while the receiver stalls;
//   the next message is gathered meanwhile and only waits if its own digest
//   is ready before the old one is taken.
//   Reset empties the block, clears the length and restarts from the
//   initial hash values; no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sha256_message_hash_assert.svh"

module sha256_message_hash (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] byte_present
  input  logic         s_axis_tlast,   // end_of_message
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata    // [63:0] digest_bytes_0_7,
                                       // [127:64] digest_bytes_8_15,
                                       // [191:128] digest_bytes_16_23,
                                       // [255:192] digest_bytes_24_31
);

  shamh_pkg::state_e    st_q, st_d;
  logic [5:0]           fill_q, fill_d;
  logic [5:0]           cnt_q, cnt_d;
  logic [63:0]          len_q, len_d;
  logic                 pad_q, pad_d, mark_q, mark_d, lenok_q, lenok_d;
  logic                 last_q, last_d, fresh_q, fresh_d;
  logic                 out_valid_q, out_valid_d;
  logic [255:0]         out_q;
  logic                 s_fire, byte_we, blk_full, out_load;
  logic [7:0]           byte_val, pad_byte;
  logic [31:0]          blk_word, chain_word, sum;
  logic [255:0]         digest;
  logic [2:0]           chain_waddr;
  logic                 chain_we;
  logic [3:0]           blk_raddr;
  shamh_pkg::core_ctl_t ctl;

  assign s_axis_tready = (st_q == shamh_pkg::ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (!mark_q) begin
      pad_byte = shamh_pkg::PadMarker;
    end else if (lenok_q && (fill_q >= shamh_pkg::LenStart)) begin
      pad_byte = len_q[{~fill_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign byte_we  = (s_fire && s_axis_tuser) || (st_q == shamh_pkg::ST_PAD);
  assign byte_val = (st_q == shamh_pkg::ST_PAD) ? pad_byte : s_axis_tdata;
  assign blk_full = byte_we && (fill_q == shamh_pkg::LastByte);
  assign out_load = (st_q == shamh_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);

  assign ctl.load  = (st_q == shamh_pkg::ST_LOAD) && (cnt_q != 6'd0);
  assign ctl.fin   = (st_q == shamh_pkg::ST_FINAL) && (cnt_q != 6'd0);
  assign ctl.round = (st_q == shamh_pkg::ST_ROUND);
  assign ctl.rnd   = cnt_q;

  // read word t+1 during round t; word 0 is fetched on the last load cycle
  assign blk_raddr   = (st_q == shamh_pkg::ST_ROUND) ? (cnt_q[3:0] + 4'd1) : 4'd0;
  // read entry n while writing entry n-1, so the two never meet
  assign chain_we    = ctl.fin;
  assign chain_waddr = cnt_q[2:0] - 3'd1;

  always_comb begin
    st_d        = st_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    pad_d       = pad_q;
    mark_d      = mark_q;
    lenok_d     = lenok_q;
    last_d      = last_q;
    fresh_d     = fresh_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (byte_we) begin
      fill_d = fill_q + 6'd1;
    end
    case (st_q)
      shamh_pkg::ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser) begin
            len_d = len_q + 64'd8;
          end
          pad_d  = s_axis_tlast;
          last_d = 1'b0;
          cnt_d  = 6'd0;
          if (blk_full) begin
            st_d = shamh_pkg::ST_LOAD;
          end else if (s_axis_tlast) begin
            st_d = shamh_pkg::ST_PAD;
          end
        end
      end
      shamh_pkg::ST_PAD: begin
        mark_d = 1'b1;
        if (!mark_q && (fill_q < shamh_pkg::LenStart)) begin
          lenok_d = 1'b1;
        end
        if (blk_full) begin
          last_d = mark_q && lenok_q;
          cnt_d  = 6'd0;
          st_d   = shamh_pkg::ST_LOAD;
        end
      end
      shamh_pkg::ST_LOAD: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == shamh_pkg::LastWord) begin
          cnt_d = 6'd0;
          st_d  = shamh_pkg::ST_ROUND;
        end
      end
      shamh_pkg::ST_ROUND: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == shamh_pkg::LastRound) begin
          cnt_d = 6'd0;
          st_d  = shamh_pkg::ST_FINAL;
        end
      end
      shamh_pkg::ST_FINAL: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == shamh_pkg::LastWord) begin
          fresh_d = 1'b0;
          if (mark_q) begin
            lenok_d = 1'b1;
          end
          if (last_q) begin
            st_d = shamh_pkg::ST_OUT;
          end else if (pad_q) begin
            st_d = shamh_pkg::ST_PAD;
          end else begin
            st_d = shamh_pkg::ST_IDLE;
          end
        end
      end
      shamh_pkg::ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          len_d       = 64'd0;
          pad_d       = 1'b0;
          mark_d      = 1'b0;
          lenok_d     = 1'b0;
          last_d      = 1'b0;
          fresh_d     = 1'b1;
          st_d        = shamh_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = shamh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= shamh_pkg::ST_IDLE;
      fill_q      <= 6'd0;
      cnt_q       <= 6'd0;
      len_q       <= 64'd0;
      pad_q       <= 1'b0;
      mark_q      <= 1'b0;
      lenok_q     <= 1'b0;
      last_q      <= 1'b0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      pad_q       <= pad_d;
      mark_q      <= mark_d;
      lenok_q     <= lenok_d;
      last_q      <= last_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= digest;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  shamh_buf u_buf (
    .clk_i     (clk_i),
    .byte_we_i (byte_we),
    .byte_i    (byte_val),
    .fill_i    (fill_q),
    .raddr_i   (blk_raddr),
    .rdata_o   (blk_word)
  );

  shamh_chain u_chain (
    .clk_i   (clk_i),
    .fresh_i (fresh_q),
    .raddr_i (cnt_q[2:0]),
    .we_i    (chain_we),
    .waddr_i (chain_waddr),
    .wdata_i (sum),
    .rdata_o (chain_word)
  );

  shamh_core u_core (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .chain_i  (chain_word),
    .blk_i    (blk_word),
    .sum_o    (sum),
    .digest_o (digest)
  );

  `SHAMH_ASSERT_NEXT(a_full_starts_load, blk_full, st_q == shamh_pkg::ST_LOAD, "full block did not start compression")
  `SHAMH_ASSERT(a_chain_no_overlap, !chain_we || (chain_waddr != cnt_q[2:0]), "chain read and write hit one entry")
  `SHAMH_ASSERT(a_round_empty_fill, (st_q != shamh_pkg::ST_ROUND) || (fill_q == 6'd0), "bytes gathered during rounds")
  `SHAMH_ASSERT_NEXT(a_out_wait, (st_q == shamh_pkg::ST_OUT) && out_valid_q && !m_axis_tready, st_q == shamh_pkg::ST_OUT, "digest overwrote a pending result")

endmodule

// ----- bench/sha256_digest_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 digest checker
// Watches both stream channels of the message hash, computes the digest of
// every message it sees accepted and compares each delivered digest with it.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         s_axis_tlast,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [255:0] m_axis_tdata,
  output int           mismatch_count_o,
  output int           digests_pending_o
);

  logic [31:0]  hash_state [8];
  logic [7:0]   msg_block [64];
  logic [63:0]  bit_length;
  int unsigned  block_fill;
  logic [255:0] digest_queue [$];

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-7]
             + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shamh_pkg::RoundK[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart();
    for (int i = 0; i < 8; i++) hash_state[i] = shamh_pkg::InitHash[i];
    bit_length = '0;
    block_fill = 0;
  endtask

  task automatic absorb(input logic [7:0] b, input logic present, input logic last);
    logic [255:0] d;
    if (present) begin
      msg_block[block_fill] = b;
      block_fill++;
      bit_length += 64'd8;
      if (block_fill == 64) begin
        compress();
        block_fill = 0;
      end
    end
    if (!last) return;
    msg_block[block_fill] = shamh_pkg::PadMarker;
    block_fill++;
    if (block_fill > shamh_pkg::LenStart) begin
      while (block_fill < 64) msg_block[block_fill++] = 8'h00;
      compress();
      block_fill = 0;
    end
    while (block_fill < shamh_pkg::LenStart) msg_block[block_fill++] = 8'h00;
    for (int i = 0; i < 8; i++)
      msg_block[shamh_pkg::LenStart + i] = bit_length[63 - 8*i -: 8];
    compress();
    for (int i = 0; i < 4; i++) d[64*i +: 64] = {hash_state[2*i], hash_state[2*i+1]};
    digest_queue = {digest_queue, d};
    restart();
  endtask

  initial begin
    restart();
    mismatch_count_o = 0;
  end

  assign digests_pending_o = digest_queue.size();

  always @(posedge clk_i) begin
    logic [255:0] want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) absorb(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (digest_queue.size() == 0) begin
          $error("digest with no message finished: %h", m_axis_tdata);
          mismatch_count_o++;
        end else begin
          want = digest_queue.pop_front();
          for (int i = 0; i < 4; i++)
            if (want[64*i +: 64] !== m_axis_tdata[64*i +: 64]) begin
              $error("digest_bytes_%0d_%0d expected %h actual %h", 8*i, 8*i+7,
                     want[64*i +: 64], m_axis_tdata[64*i +: 64]);
              mismatch_count_o++;
            end
        end
      end
    end
  end
endmodule

// ----- bench/tb_sha256_message_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hash testbench
// Feeds directed and random messages of many lengths through the byte stream
// with varied sender gaps and receiver stalls; the checker scores each digest.
// ----------------------------------------------------------------------------
module tb_sha256_message_hash;
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;
  int           mismatch_count;
  int           digests_pending;
  int unsigned  send_gap_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  hold_off_cycles = 0;
  int unsigned  items_sent = 0;
  int unsigned  end_count = 0;

  always #6 clk_i = ~clk_i;

  sha256_message_hash dut (.*);

  sha256_digest_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .mismatch_count_o(mismatch_count), .digests_pending_o(digests_pending)
  );

  // Receiver: random stalls, with one long hold-off counted down here.
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one item, with random idle cycles in front, and hold until taken.
  task automatic send_item(input logic [7:0] b, input logic present, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= present;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (last) end_count++;
  endtask

  // Message of n bytes; the final byte rides with tlast or an empty item ends it.
  task automatic send_message(input int n, input bit empty_end);
    for (int i = 0; i < n; i++)
      send_item(8'($urandom_range(255)), 1'b1, !empty_end && i == n - 1);
    if (empty_end || n == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(0, 12);
    if (r < 80) return $urandom_range(50, 70);
    if (r < 95) return $urandom_range(110, 135);
    return $urandom_range(180, 260);
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty message, byte extremes, pad boundaries, idle no-op items.
    send_message(0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(63, 1'b0);
    send_message(64, 1'b1);
    for (int phase = 0; phase < 4; phase++) begin
      send_gap_pct = (phase == 1 || phase == 3) ? (phase == 3 ? 30 : 49) : 0;
      stall_pct    = (phase == 2 || phase == 3) ? (phase == 3 ? 30 : 49) : 0;
      if (phase == 2) hold_off_cycles = 3000;
      while (items_sent < 500 * (phase + 1))
        if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
        else send_message(pick_length(), $urandom_range(3) == 0);
    end
    // Length wrap cannot be reached in a run; only the low bits of the length field
    // are exercised here.
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (digests_pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
